@@ src/wfq_pkg.sv @@
// ----------------------------------------------------------------------------
// wfq_pkg
// Shared widths, register indexes and codes of the head-of-line scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package wfq_pkg;

   // queues and field widths
   localparam int NUM_QUEUES  = 3;
   localparam int QIDX_W      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int QSEL_W      = 2;
   localparam int HANDLE_BITS = 16;
   localparam int LEN_W       = 16;
   localparam int TIME_W      = 64;
   localparam int WEIGHT_W    = 8;
   localparam int WSUM_W      = WEIGHT_W + 2;
   localparam int RATE_W      = 19;
   localparam int TICK_W      = 33;

   // stream payload widths
   localparam int REQ_DATA_W  = 104;
   localparam int RSP_DATA_W  = 88;
   localparam int RSP_USER_W  = 2;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 33;

   localparam logic [CSR_INDEX_W-1:0] REG_WEIGHT_ZERO = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WEIGHT_ONE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WEIGHT_TWO  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LINK_RATE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TICK_HZ     = 3'd4;

   // request kinds
   localparam logic ACT_OFFER    = 1'b0;
   localparam logic ACT_SCHEDULE = 1'b1;

   // serial multiplier: one multiplier bit per cycle
   localparam int MUL_BITS    = 20;
   localparam int MUL_COUNT_W = $clog2(MUL_BITS + 1);

   // serial divider: one quotient bit per cycle
   localparam int DIV_COUNT_W = $clog2(TIME_W);

   // constant factors
   localparam logic [MUL_BITS-1:0] US_PER_SEC    = 20'd1000000;
   localparam int                  BYTE_SHIFT    = 3;

endpackage : wfq_pkg

`default_nettype wire

@@ src/wfq_ser_mul.sv @@
// ----------------------------------------------------------------------------
// wfq_ser_mul
// Shift-add multiplier, one multiplier bit per cycle, product modulo 2^64.
// ----------------------------------------------------------------------------
`default_nettype none

module wfq_ser_mul
   import wfq_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [TIME_W-1:0]   mcand,
   input  wire logic [MUL_BITS-1:0] mplier,
   output logic                     done,
   output logic [TIME_W-1:0]        product
);

   logic [TIME_W-1:0]      acc_ff, acc_in;
   logic [TIME_W-1:0]      mcand_ff, mcand_in;
   logic [MUL_BITS-1:0]    mplier_ff, mplier_in;
   logic [MUL_COUNT_W-1:0] count_ff, count_in;
   logic                   run_ff, run_in;
   logic                   done_ff, done_in;

   // next state: load on start, else add one partial product
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      count_in  = count_ff;
      run_in    = run_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = mcand;
         mplier_in = mplier;
         count_in  = MUL_COUNT_W'(MUL_BITS);
         run_in    = 1'b1;
      end else if (run_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[TIME_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[MUL_BITS-1:1]};
         count_in  = count_ff - MUL_COUNT_W'(1);
         if (count_ff == MUL_COUNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      count_ff  <= count_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule : wfq_ser_mul

`default_nettype wire

@@ src/wfq_ser_div.sv @@
// ----------------------------------------------------------------------------
// wfq_ser_div
// Restoring divider, one quotient bit per cycle; a zero divisor gives all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module wfq_ser_div
   import wfq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [TIME_W-1:0] dividend,
   input  wire logic [TIME_W-1:0] divisor,
   output logic                   done,
   output logic [TIME_W-1:0]      quotient
);

   logic [TIME_W-1:0]      quo_ff, quo_in;
   logic [TIME_W-1:0]      rem_ff, rem_in;
   logic [TIME_W-1:0]      den_ff, den_in;
   logic [DIV_COUNT_W-1:0] count_ff, count_in;
   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [TIME_W:0]        shifted;
   logic                   fits;

   // one restoring step: bring in the next dividend bit, try a subtract
   always_comb begin
      shifted  = {rem_ff, quo_ff[TIME_W-1]};
      fits     = (shifted >= {1'b0, den_ff});
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      count_in = count_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         den_in   = divisor;
         count_in = DIV_COUNT_W'(TIME_W - 1);
         run_in   = 1'b1;
      end else if (run_ff) begin
         if (fits) begin
            rem_in = TIME_W'(shifted - {1'b0, den_ff});
         end else begin
            rem_in = TIME_W'(shifted);
         end
         quo_in   = {quo_ff[TIME_W-2:0], fits};
         count_in = count_ff - DIV_COUNT_W'(1);
         if (count_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      count_ff <= count_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule : wfq_ser_div

`default_nettype wire

@@ src/wfq_head_of_line_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// wfq_head_of_line_scheduler_core
// Weighted fair queuing head-of-line scheduler: one head per queue, offers
// compute a departure time, schedule requests pop the earliest head.
// ----------------------------------------------------------------------------
// Offer into an empty slot: two bit-serial multiply passes and the 64-step divider
// compute the departure time before the response state. Offer to a full or unknown
// slot: straight to the response state. Schedule: one slot compared per cycle.
// One item at a time: the next request beat can be taken once the result is in the
// output register; the response state waits while a held result is not accepted.
// Reset clears valid bits, the sequencer and the configuration; not slot data.
`default_nettype none

module wfq_head_of_line_scheduler_core
   import wfq_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // queue_sel[1:0], pkt_length[17:2], arrival_time[81:18], pkt_handle[97:82]
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // action[0]
   input  wire logic                   req_tuser,
   // response stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // out_queue[1:0], out_handle[17:2], out_departure[81:18]
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   // accepted[0], out_valid[1]
   output logic [RSP_USER_W-1:0]       rsp_tuser,
   // register writes
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_RESP = 3'd4;

   // configuration
   logic [WEIGHT_W-1:0] weight_zero_ff, weight_one_ff, weight_two_ff;
   logic [RATE_W-1:0]   link_rate_ff;
   logic [TICK_W-1:0]   tick_hz_ff;

   // slots
   logic [NUM_QUEUES-1:0]  head_valid_ff, head_valid_in;
   logic [TIME_W-1:0]      head_dep_ff [NUM_QUEUES];
   logic [HANDLE_BITS-1:0] head_tag_ff [NUM_QUEUES];
   logic                   slot_write;

   // sequencer and latched request
   logic [2:0]             state_ff, state_in;
   logic                   act_ff, act_in;
   logic [QIDX_W-1:0]      qidx_ff, qidx_in;
   logic [TIME_W-1:0]      arr_ff, arr_in;
   logic [HANDLE_BITS-1:0] tag_ff, tag_in;
   logic                   stage_ff, stage_in;
   logic                   pend_acc_ff, pend_acc_in;
   logic [TIME_W-1:0]      dep_calc_ff, dep_calc_in;

   // scan of the slots
   logic [QIDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                   found_ff, found_in;
   logic [QIDX_W-1:0]      best_q_ff, best_q_in;
   logic [TIME_W-1:0]      best_dep_ff, best_dep_in;
   logic [HANDLE_BITS-1:0] best_tag_ff, best_tag_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]  rsp_user_ff, rsp_user_in;

   // arithmetic units
   logic                   mul_start, div_start;
   logic [TIME_W-1:0]      num_mcand, den_mcand;
   logic [MUL_BITS-1:0]    num_mplier, den_mplier;
   logic                   num_done, den_done, div_done;
   logic [TIME_W-1:0]      num_prod, den_prod, quotient;

   // request fields
   logic [QSEL_W-1:0]      req_qsel;
   logic [LEN_W-1:0]       req_len;
   logic [TIME_W-1:0]      req_arr;
   logic [HANDLE_BITS-1:0] req_tag;
   logic                   req_fire, out_free;
   logic                   slot_busy;
   logic [WEIGHT_W-1:0]    q_weight;
   logic [WSUM_W-1:0]      wsum;

   assign req_qsel = req_tdata[1:0];
   assign req_len  = req_tdata[17:2];
   assign req_arr  = req_tdata[81:18];
   assign req_tag  = req_tdata[97:82];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // occupancy of the offered slot; unknown queues count as busy
   always_comb begin
      slot_busy = 1'b1;
      for (int q = 0; q < NUM_QUEUES; q++) begin
         if (32'(req_qsel) == q) begin
            slot_busy = head_valid_ff[q];
         end
      end
   end

   // weight of the latched queue, higher queues share weight_two
   always_comb begin
      if (qidx_ff == QIDX_W'(0)) begin
         q_weight = weight_zero_ff;
      end else if (qidx_ff == QIDX_W'(1)) begin
         q_weight = weight_one_ff;
      end else begin
         q_weight = weight_two_ff;
      end
   end

   assign wsum = WSUM_W'(weight_zero_ff) + WSUM_W'(weight_one_ff) + WSUM_W'(weight_two_ff);

   // operands: first pass len*8*tick_hz and rate*1e6, then times wsum and weight
   always_comb begin
      if (state_ff == ST_IDLE) begin
         num_mcand  = TIME_W'(tick_hz_ff);
         num_mplier = MUL_BITS'({req_len, {BYTE_SHIFT{1'b0}}});
         den_mcand  = TIME_W'(link_rate_ff);
         den_mplier = US_PER_SEC;
      end else begin
         num_mcand  = num_prod;
         num_mplier = MUL_BITS'(wsum);
         den_mcand  = den_prod;
         den_mplier = MUL_BITS'(q_weight);
      end
   end

   wfq_ser_mul u_num_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (num_mcand),
      .mplier  (num_mplier),
      .done    (num_done),
      .product (num_prod)
   );

   wfq_ser_mul u_den_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (den_mcand),
      .mplier  (den_mplier),
      .done    (den_done),
      .product (den_prod)
   );

   wfq_ser_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_prod),
      .divisor  (den_prod),
      .done     (div_done),
      .quotient (quotient)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      qidx_in       = qidx_ff;
      arr_in        = arr_ff;
      tag_in        = tag_ff;
      stage_in      = stage_ff;
      pend_acc_in   = pend_acc_ff;
      dep_calc_in   = dep_calc_ff;
      scan_idx_in   = scan_idx_ff;
      found_in      = found_ff;
      best_q_in     = best_q_ff;
      best_dep_in   = best_dep_ff;
      best_tag_in   = best_tag_ff;
      head_valid_in = head_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      mul_start     = 1'b0;
      div_start     = 1'b0;
      slot_write    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               act_in      = req_tuser;
               qidx_in     = QIDX_W'(req_qsel);
               arr_in      = req_arr;
               tag_in      = req_tag;
               scan_idx_in = '0;
               found_in    = 1'b0;
               pend_acc_in = 1'b0;
               stage_in    = 1'b0;
               if (req_tuser == ACT_SCHEDULE) begin
                  state_in = ST_SCAN;
               end else if (!slot_busy) begin
                  mul_start = 1'b1;
                  state_in  = ST_MUL;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_MUL: begin
            if (num_done && den_done) begin
               if (!stage_ff) begin
                  stage_in  = 1'b1;
                  mul_start = 1'b1;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               dep_calc_in = arr_ff + quotient;
               pend_acc_in = 1'b1;
               state_in    = ST_RESP;
            end
         end
         ST_SCAN: begin
            if (head_valid_ff[scan_idx_ff] &&
                (!found_ff || (head_dep_ff[scan_idx_ff] < best_dep_ff))) begin
               found_in    = 1'b1;
               best_q_in   = scan_idx_ff;
               best_dep_in = head_dep_ff[scan_idx_ff];
               best_tag_in = head_tag_ff[scan_idx_ff];
            end
            scan_idx_in = scan_idx_ff + QIDX_W'(1);
            if (scan_idx_ff == QIDX_W'(NUM_QUEUES - 1)) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_user_in  = '0;
               if (act_ff == ACT_OFFER) begin
                  rsp_user_in[0] = pend_acc_ff;
                  if (pend_acc_ff) begin
                     slot_write             = 1'b1;
                     head_valid_in[qidx_ff] = 1'b1;
                  end
               end else if (found_ff) begin
                  rsp_user_in[1]          = 1'b1;
                  rsp_data_in[1:0]        = QSEL_W'(best_q_ff);
                  rsp_data_in[17:2]       = best_tag_ff;
                  rsp_data_in[81:18]      = best_dep_ff;
                  head_valid_in[best_q_ff] = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_valid_ff <= head_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_zero_ff <= WEIGHT_W'(1);
         weight_one_ff  <= WEIGHT_W'(1);
         weight_two_ff  <= WEIGHT_W'(1);
         link_rate_ff   <= RATE_W'(10000);
         tick_hz_ff     <= TICK_W'(1000000000);
      end else if (csr_wen) begin
         case (csr_index)
            REG_WEIGHT_ZERO: weight_zero_ff <= csr_wdata[WEIGHT_W-1:0];
            REG_WEIGHT_ONE:  weight_one_ff  <= csr_wdata[WEIGHT_W-1:0];
            REG_WEIGHT_TWO:  weight_two_ff  <= csr_wdata[WEIGHT_W-1:0];
            REG_LINK_RATE:   link_rate_ff   <= csr_wdata[RATE_W-1:0];
            REG_TICK_HZ:     tick_hz_ff     <= csr_wdata[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      qidx_ff     <= qidx_in;
      arr_ff      <= arr_in;
      tag_ff      <= tag_in;
      stage_ff    <= stage_in;
      pend_acc_ff <= pend_acc_in;
      dep_calc_ff <= dep_calc_in;
      scan_idx_ff <= scan_idx_in;
      found_ff    <= found_in;
      best_q_ff   <= best_q_in;
      best_dep_ff <= best_dep_in;
      best_tag_ff <= best_tag_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (slot_write) begin
         head_dep_ff[qidx_ff] <= dep_calc_ff;
         head_tag_ff[qidx_ff] <= tag_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule : wfq_head_of_line_scheduler_core

`default_nettype wire

@@ test/wfq_head_of_line_scheduler_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wfq_head_of_line_scheduler_core_tb
// Self-checking bench for the head-of-line scheduler. A queue-fed driver
// offers heads and schedule requests, a copy of the slot state updated per
// request beat predicts each response beat, and a monitor compares every
// beat field by field. Runs cover default, extreme, zero-divisor and random
// settings under several idle patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------

module wfq_head_of_line_scheduler_core_tb;
   import wfq_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 130;
   localparam int HOLD_CYCLES   = 2000;
   localparam int HALF_ITEMS    = 250;

   typedef struct packed {
      logic                   action;
      logic [QSEL_W-1:0]      qsel;
      logic [LEN_W-1:0]       len;
      logic [TIME_W-1:0]      arrival;
      logic [HANDLE_BITS-1:0] handle;
   } sched_req_type;

   typedef struct packed {
      logic                   accepted;
      logic                   out_valid;
      logic [QSEL_W-1:0]      queue;
      logic [HANDLE_BITS-1:0] handle;
      logic [TIME_W-1:0]      departure;
   } sched_rsp_type;

   // dut ports
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // shadow registers and slot state
   logic [WEIGHT_W-1:0]    cfg_weight [3];
   logic [RATE_W-1:0]      cfg_rate;
   logic [TICK_W-1:0]      cfg_tick;
   logic                   slot_valid [NUM_QUEUES];
   logic [TIME_W-1:0]      slot_departure [NUM_QUEUES];
   logic [HANDLE_BITS-1:0] slot_tag [NUM_QUEUES];

   sched_req_type pending_requests [$];
   sched_rsp_type awaited_results [$];
   sched_req_type next_req;
   sched_rsp_type seen_rsp;
   sched_rsp_type want_rsp;

   int  requests_queued = 0;
   int  requests_taken = 0;
   int  fail_count = 0;
   int  cycle_count = 0;
   int  sender_idle_pct = 0;
   int  receiver_idle_pct = 0;
   int  hold_left = 0;
   bit  hold_req = 1'b0;
   bit  hold_taken = 1'b0;
   bit  req_fire = 1'b0;
   logic [TIME_W-1:0] time_base = '0;
   logic [TIME_W-1:0] tie_time = '0;

   wfq_head_of_line_scheduler_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // departure = arrival + transmission ticks, ticks all ones on a zero divisor
   function logic [TIME_W-1:0] compute_departure(int q, logic [LEN_W-1:0] len,
                                                 logic [TIME_W-1:0] arrival);
      logic [63:0] wsum;
      logic [63:0] wq;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] tx;
      wsum = 64'(cfg_weight[0]) + 64'(cfg_weight[1]) + 64'(cfg_weight[2]);
      wq   = (q == 0) ? 64'(cfg_weight[0]) : (q == 1) ? 64'(cfg_weight[1])
                                                      : 64'(cfg_weight[2]);
      num  = 64'(len) * 64'd8 * 64'(cfg_tick) * wsum;
      den  = 64'(US_PER_SEC) * 64'(cfg_rate) * wq;
      tx   = (den == 64'd0) ? '1 : num / den;
      return arrival + tx;
   endfunction

   // update the slot copy for one request and return the beat it causes
   function sched_rsp_type apply_request(sched_req_type r);
      sched_rsp_type res;
      int            best;
      bit            found;
      res   = '0;
      best  = 0;
      found = 1'b0;
      if (r.action == ACT_OFFER) begin
         if (r.qsel < NUM_QUEUES && !slot_valid[r.qsel]) begin
            slot_valid[r.qsel]     = 1'b1;
            slot_tag[r.qsel]       = r.handle;
            slot_departure[r.qsel] = compute_departure(int'(r.qsel), r.len, r.arrival);
            res.accepted           = 1'b1;
         end
      end else begin
         for (int q = 0; q < NUM_QUEUES; q++) begin
            if (slot_valid[q] && (!found || slot_departure[q] < slot_departure[best])) begin
               best  = q;
               found = 1'b1;
            end
         end
         if (found) begin
            slot_valid[best] = 1'b0;
            res.out_valid    = 1'b1;
            res.queue        = QSEL_W'(best);
            res.handle       = slot_tag[best];
            res.departure    = slot_departure[best];
         end
      end
      return res;
   endfunction

   function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // request driver: next beat presented at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_req   = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_req.action;
            req_tdata  <= {6'b0, next_req.handle, next_req.arrival, next_req.len,
                           next_req.qsel};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready: random idling plus one long hold-off
   always @(negedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // monitor: predict on request beats, compare on response beats
   always @(posedge clock) begin
      cycle_count++;
      req_fire = !reset && req_tvalid && req_tready;
      if (req_fire) begin
         awaited_results.push_back(apply_request({req_tuser, req_tdata[1:0],
                                                  req_tdata[17:2], req_tdata[81:18],
                                                  req_tdata[97:82]}));
         requests_taken++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp = {rsp_tuser[0], rsp_tuser[1], rsp_tdata[1:0], rsp_tdata[17:2],
                     rsp_tdata[81:18]};
         if (awaited_results.size() == 0) begin
            $error("response beat with nothing outstanding");
            fail_count++;
         end else begin
            want_rsp = awaited_results.pop_front();
            check_field("accepted", 64'(want_rsp.accepted), 64'(seen_rsp.accepted));
            check_field("out_valid", 64'(want_rsp.out_valid), 64'(seen_rsp.out_valid));
            check_field("out_queue", 64'(want_rsp.queue), 64'(seen_rsp.queue));
            check_field("out_handle", 64'(want_rsp.handle), 64'(seen_rsp.handle));
            check_field("out_departure", want_rsp.departure, seen_rsp.departure);
         end
      end
   end

   task queue_request(sched_req_type r);
      pending_requests.push_back(r);
      requests_queued++;
   endtask

   task queue_offer(logic [QSEL_W-1:0] q, logic [LEN_W-1:0] len,
                    logic [TIME_W-1:0] arrival, logic [HANDLE_BITS-1:0] handle);
      queue_request({ACT_OFFER, q, len, arrival, handle});
   endtask

   task queue_schedule(int count);
      for (int n = 0; n < count; n++)
         queue_request({ACT_SCHEDULE, {QSEL_W{1'b0}}, {LEN_W{1'b0}}, {TIME_W{1'b0}},
                        {HANDLE_BITS{1'b0}}});
   endtask

   // wait for every outstanding beat, then let the core go quiet
   task wait_until_drained();
      while (requests_taken != requests_queued || awaited_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         REG_WEIGHT_ZERO: cfg_weight[0] = value[WEIGHT_W-1:0];
         REG_WEIGHT_ONE:  cfg_weight[1] = value[WEIGHT_W-1:0];
         REG_WEIGHT_TWO:  cfg_weight[2] = value[WEIGHT_W-1:0];
         REG_LINK_RATE:   cfg_rate      = value[RATE_W-1:0];
         REG_TICK_HZ:     cfg_tick      = value[TICK_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task load_settings(logic [WEIGHT_W-1:0] w0, logic [WEIGHT_W-1:0] w1,
                      logic [WEIGHT_W-1:0] w2, logic [RATE_W-1:0] rate,
                      logic [TICK_W-1:0] tick);
      write_reg(REG_WEIGHT_ZERO, CSR_DATA_W'(w0));
      write_reg(REG_WEIGHT_ONE, CSR_DATA_W'(w1));
      write_reg(REG_WEIGHT_TWO, CSR_DATA_W'(w2));
      write_reg(REG_LINK_RATE, CSR_DATA_W'(rate));
      write_reg(REG_TICK_HZ, CSR_DATA_W'(tick));
   endtask

   task load_random_settings();
      logic [TICK_W-1:0] tick;
      tick = {1'($urandom_range(1)), 32'($urandom)};
      if (tick == '0)
         tick = TICK_W'(1);
      load_settings(WEIGHT_W'($urandom_range(1, 255)), WEIGHT_W'($urandom_range(1, 255)),
                    WEIGHT_W'($urandom_range(1, 255)),
                    RATE_W'($urandom_range(1, 400000)), tick);
   endtask

   // mostly offers to real queues and pops, some out-of-range offers
   task queue_random_traffic(int count);
      sched_req_type r;
      int            roll;
      tie_time = {32'($urandom), 32'($urandom)};
      for (int n = 0; n < count; n++) begin
         roll      = $urandom_range(99);
         r.len     = LEN_W'($urandom);
         r.handle  = HANDLE_BITS'($urandom);
         r.arrival = {32'($urandom), 32'($urandom)};
         r.qsel    = QSEL_W'($urandom_range(2));
         if (roll < 45) begin
            // schedule beat with noise in the unused fields
            r.action = ACT_SCHEDULE;
            r.qsel   = QSEL_W'($urandom_range(3));
         end else begin
            r.action = ACT_OFFER;
            if (roll < 50)
               r.qsel = 2'd3;
            case ($urandom_range(7))
               0: r.len = '0;
               1: r.len = '1;
               2, 3: r.len = LEN_W'($urandom_range(40, 1500));
               default: ;
            endcase
            case ($urandom_range(7))
               0, 1: ;
               2: begin
                  r.arrival = tie_time;
                  r.len     = '0;
               end
               3: r.arrival = '1 - TIME_W'($urandom_range(1000));
               default: begin
                  time_base += TIME_W'($urandom_range(2000));
                  r.arrival = time_base;
               end
            endcase
         end
         queue_request(r);
      end
   endtask

   // stimulus sequence
   initial begin
      cfg_weight[0] = WEIGHT_W'(1);
      cfg_weight[1] = WEIGHT_W'(1);
      cfg_weight[2] = WEIGHT_W'(1);
      cfg_rate      = RATE_W'(10000);
      cfg_tick      = TICK_W'(1000000000);
      for (int q = 0; q < NUM_QUEUES; q++)
         slot_valid[q] = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset defaults: empty pop, occupied slot, bad queue, tie, wrapping sum
      queue_schedule(1);
      queue_offer(2'd0, 16'd0, 64'd0, 16'h0000);
      queue_offer(2'd0, 16'hFFFF, '1, 16'hFFFF);
      queue_offer(2'd3, 16'hFFFF, '1, 16'hFFFF);
      queue_offer(2'd2, 16'd0, 64'd0, 16'h1234);
      queue_offer(2'd1, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFF0, 16'hFFFF);
      queue_schedule(4);
      wait_until_drained();

      // largest weights and rate, one zero weight gives its queue all-ones ticks
      load_settings(8'd255, 8'd0, 8'd255, 19'd400000, '1);
      queue_offer(2'd0, 16'hFFFF, 64'd0, 16'hAAAA);
      queue_offer(2'd1, 16'd1, 64'd5, 16'h5555);
      queue_offer(2'd2, 16'hFFFF, '1, 16'h00FF);
      queue_schedule(3);
      wait_until_drained();

      // zero link rate gives every queue all-ones ticks
      load_settings(8'd1, 8'd1, 8'd1, 19'd0, 33'd1);
      queue_offer(2'd0, 16'd0, 64'h8000_0000_0000_0000, 16'hFF00);
      queue_offer(2'd2, 16'd100, 64'd1, 16'h0F0F);
      queue_schedule(2);
      wait_until_drained();

      // sender rarely idle, receiver often idle
      sender_idle_pct   = 9;
      receiver_idle_pct = 69;
      load_random_settings();
      queue_random_traffic(HALF_ITEMS);
      wait_until_drained();
      load_random_settings();
      queue_random_traffic(HALF_ITEMS);
      wait_until_drained();

      // sender often idle, receiver rarely idle, extreme settings
      sender_idle_pct   = 69;
      receiver_idle_pct = 9;
      load_settings(8'd255, 8'd255, 8'd255, 19'd400000, '1);
      queue_random_traffic(HALF_ITEMS);
      wait_until_drained();
      load_settings(8'd1, 8'd255, 8'd1, 19'd1, 33'd1);
      queue_random_traffic(HALF_ITEMS);
      wait_until_drained();

      // no idling, with one long receiver hold-off
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      load_random_settings();
      queue_random_traffic(HALF_ITEMS);
      hold_req = 1'b1;
      wait_until_drained();
      load_settings(8'd1, 8'd1, 8'd1, 19'd10000, 33'd1000000000);
      queue_random_traffic(HALF_ITEMS);
      wait_until_drained();

      if (fail_count == 0)
         $display("wfq_head_of_line_scheduler_core_tb passed");
      else
         $display("wfq_head_of_line_scheduler_core_tb failed");
      $finish;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("wfq_head_of_line_scheduler_core_tb failed");
      $finish;
   end

endmodule

@@ sim.f @@
src/wfq_pkg.sv
src/wfq_ser_mul.sv
src/wfq_ser_div.sv
src/wfq_head_of_line_scheduler_core.sv
test/wfq_head_of_line_scheduler_core_tb.sv
